// ===== hdl/mqrf_pkg.sv =====
`default_nettype none

package mqrf_pkg;

   // Operation codes carried in the mode field.
   localparam logic [1:0] MODE_INIT  = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_WRITE = 2'd2;

   // Result status codes.
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BOUNDS = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   localparam int MODE_W   = 2;
   localparam int INDEX_W  = 4;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 5;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   // Commands from the sequencer to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
      logic load;
   } cmd_type;

   // Status from the datapath back to the sequencer.
   typedef struct packed {
      logic read_hit;
   } stat_type;

endpackage

`default_nettype wire

// ===== hdl/mqrf_ram.sv =====
`default_nettype none

module mqrf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/mqrf_ctrl.sv =====
`default_nettype none

module mqrf_ctrl
   import mqrf_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  wire logic     rsp_tready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_LOAD = 2'd2;
   localparam logic [1:0] S_RESP = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      cmd.load    = 1'b0;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
            // A successful pop passes through the load state to pick up the RAM output.
            state_in = stat.read_hit ? S_LOAD : S_RESP;
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/mqrf_datapath.sv =====
`default_nettype none

module mqrf_datapath
   import mqrf_pkg::*;
#(
   parameter int QUEUE_COUNT = 4,
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cmd_type             cmd,
   output stat_type                 stat,
   input  wire logic [MODE_W-1:0]   mode,
   input  wire logic [INDEX_W-1:0]  queue_index,
   input  wire logic [WORD_W-1:0]   write_word,
   output logic      [STATUS_W-1:0] status,
   output logic      [WORD_W-1:0]   read_word,
   output logic      [FILL_W-1:0]   fill_level
);

   localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int AW = $clog2(QUEUE_COUNT * QUEUE_DEPTH);

   logic [MODE_W-1:0]   mode_ff;
   logic [INDEX_W-1:0]  index_ff;
   logic [WORD_W-1:0]   wword_ff;

   logic [PW-1:0]       rd_ptr_ff [QUEUE_COUNT];
   logic [PW-1:0]       wr_ptr_ff [QUEUE_COUNT];
   logic [CW-1:0]       count_ff  [QUEUE_COUNT];

   logic [STATUS_W-1:0] status_ff, status_in;
   logic [WORD_W-1:0]   word_ff;
   logic [FILL_W-1:0]   fill_ff, fill_in;

   logic                out_of_range;
   logic [QW-1:0]       sel;
   logic [PW-1:0]       rd_ptr, wr_ptr;
   logic [CW-1:0]       count, count_in;
   logic                is_empty, is_full;
   logic                do_init, do_pop, do_push;
   logic [AW-1:0]       base, rd_addr, wr_addr;
   logic [WORD_W-1:0]   ram_rdata;
   logic [CW+FILL_W-1:0] fill_wide;

   function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
      next_slot = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= mode;
         index_ff <= queue_index;
         wword_ff <= write_word;
      end
   end

   assign out_of_range = ({1'b0, index_ff} >= (INDEX_W + 1)'(QUEUE_COUNT));
   assign sel          = index_ff[QW-1:0];
   assign rd_ptr       = rd_ptr_ff[sel];
   assign wr_ptr       = wr_ptr_ff[sel];
   assign count        = count_ff[sel];
   assign is_empty     = (count == '0);
   assign is_full      = (count >= CW'(QUEUE_DEPTH));

   assign do_init = !out_of_range && (mode_ff == MODE_INIT);
   assign do_pop  = !out_of_range && (mode_ff == MODE_READ) && !is_empty;
   assign do_push = !out_of_range && (mode_ff == MODE_WRITE) && !is_full;

   assign stat.read_hit = do_pop;

   // Each queue owns a contiguous slice of the word store.
   assign base    = AW'(sel) * AW'(QUEUE_DEPTH);
   assign rd_addr = base + AW'(rd_ptr);
   assign wr_addr = base + AW'(wr_ptr);

   mqrf_ram #(
      .WIDTH(WORD_W),
      .DEPTH(QUEUE_COUNT * QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.execute && do_push),
      .wr_addr (wr_addr),
      .wr_data (wword_ff),
      .rd_en   (cmd.execute && do_pop),
      .rd_addr (rd_addr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      count_in  = count;
      status_in = ST_OK;
      if (do_init) begin
         count_in = '0;
      end else if (do_pop) begin
         count_in = count - 1'b1;
      end else if (do_push) begin
         count_in = count + 1'b1;
      end
      if (out_of_range) begin
         status_in = ST_BOUNDS;
      end else if (mode_ff == MODE_READ && is_empty) begin
         status_in = ST_EMPTY;
      end else if (mode_ff == MODE_WRITE && is_full) begin
         status_in = ST_FULL;
      end
      fill_wide = {{FILL_W{1'b0}}, count_in};
      fill_in   = out_of_range ? '0 : fill_wide[FILL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUEUE_COUNT; i++) begin
            rd_ptr_ff[i] <= '0;
            wr_ptr_ff[i] <= '0;
            count_ff[i]  <= '0;
         end
      end else if (cmd.execute && !out_of_range) begin
         count_ff[sel] <= count_in;
         if (do_init) begin
            rd_ptr_ff[sel] <= '0;
            wr_ptr_ff[sel] <= '0;
         end else if (do_pop) begin
            rd_ptr_ff[sel] <= next_slot(rd_ptr);
         end else if (do_push) begin
            wr_ptr_ff[sel] <= next_slot(wr_ptr);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff <= status_in;
         fill_ff   <= fill_in;
         word_ff   <= '0;
      end else if (cmd.load) begin
         word_ff <= ram_rdata;
      end
   end

   assign status     = status_ff;
   assign read_word  = word_ff;
   assign fill_level = fill_ff;

endmodule

`default_nettype wire

// ===== hdl/multi_queue_ring_fifo.sv =====
// Sequence: an item is accepted in the idle state, then the sequencer walks the execute state,
// a load state that registers the word-store output (successful reads only) and the response
// state, where the result is offered. A new item is taken only once the result has been taken,
// so a held result stalls input.
// Reset: synchronous, active high; every queue becomes empty and all pointers
// return to zero. The word store itself is not cleared.
`default_nettype none

module multi_queue_ring_fifo
   import mqrf_pkg::*;
#(
   parameter int QUEUE_COUNT = 4,
   parameter int QUEUE_DEPTH = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // mode[1:0], queue_index[5:2], write_word[37:6], zero fill[39:38]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // status[1:0], read_word[33:2], fill_level[38:34], zero fill[39]
   output logic      [RSP_DATA_W-1:0] rsp_tdata
);

   cmd_type             cmd;
   stat_type            stat;
   logic [STATUS_W-1:0] status;
   logic [WORD_W-1:0]   read_word;
   logic [FILL_W-1:0]   fill_level;

   mqrf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mqrf_datapath #(
      .QUEUE_COUNT(QUEUE_COUNT),
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .mode        (req_tdata[1:0]),
      .queue_index (req_tdata[5:2]),
      .write_word  (req_tdata[37:6]),
      .status      (status),
      .read_word   (read_word),
      .fill_level  (fill_level)
   );

   assign rsp_tdata = {1'b0, fill_level, read_word, status};

endmodule

`default_nettype wire

// ===== hdl/mqrf_checker.sv =====
`default_nettype none

module mqrf_checker
   import mqrf_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW+FILL_W-1:0] DEPTH_WIDE = (CW + FILL_W)'(QUEUE_DEPTH);

   // A result stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn before it was taken");

   // Only one item is in flight: no new item while a result is pending.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while a result is pending");

   // After an item is taken the block is busy for at least the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready && !rsp_tvalid)
      else $error("block not busy right after accepting an item");

   // An empty or out-of-range answer carries no word and no fill level.
   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] == ST_EMPTY || rsp_tdata[1:0] == ST_BOUNDS)
      |-> rsp_tdata[38:2] == '0)
      else $error("empty or out-of-range result carries data");

   // A refused write reports the queue as holding its full depth.
   a_full_level: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == ST_FULL
      |-> rsp_tdata[38:34] == DEPTH_WIDE[FILL_W-1:0] && rsp_tdata[33:2] == '0)
      else $error("full result with wrong fill level or word");

endmodule

bind multi_queue_ring_fifo mqrf_checker #(
   .QUEUE_DEPTH(QUEUE_DEPTH)
) u_mqrf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
